FILE: rtl/three_queue_budget_dispatch_arbiter_top_macros.svh
// Assertion helpers for the dispatch arbiter.
`ifndef THREE_QUEUE_BUDGET_DISPATCH_ARBITER_TOP_MACROS_SVH
`define THREE_QUEUE_BUDGET_DISPATCH_ARBITER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TQBDA_CHECK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tqbda check failed");
// next-cycle implication
`define TQBDA_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tqbda check failed");
`else
`define TQBDA_CHECK_NOW(lbl, ante, cons)
`define TQBDA_CHECK_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/tqbda_pkg.sv
package tqbda_pkg;

    localparam int NUM_CPUS   = 64;
    localparam int CNT_ADDR_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int CPU_W      = 6;
    localparam int CNT_W      = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CNT_W-1:0] DEFAULT_SHARED_BUDGET = 16'd3;
    localparam logic [CNT_W-1:0] DEFAULT_COMP_BUDGET   = 16'd2;
    localparam logic [CNT_W-1:0] COUNT_MAX             = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_SHARED_BUDGET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COMP_BUDGET   = 1'b1;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_SHARED = 2'd1,
        Q_SUPER  = 2'd2,
        Q_COMP   = 2'd3
    } queue_t;

    typedef struct packed {
        logic [CPU_W-1:0] cpu_index;
        logic             shared_ready;
        logic             super_ready;
        logic             compaction_ready;
        logic             shared_overdue;
        logic             super_overdue;
        logic             compaction_overdue;
    } req_t;

    typedef struct packed {
        queue_t           granted_queue;
        logic             wait_override;
        logic [CNT_W-1:0] run_count;
    } grant_t;

    typedef struct packed {
        grant_t           result;
        logic             cnt_write;
        logic [CNT_W-1:0] cnt_next;
    } decision_t;

endpackage

FILE: rtl/tqbda_ram.sv
module tqbda_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read-first on a same-address collision
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/tqbda_decide.sv
module tqbda_decide (
    input  tqbda_pkg::req_t                    req,
    input  logic                               in_range,
    input  logic [tqbda_pkg::CNT_W-1:0]        count,
    input  logic [tqbda_pkg::CFG_W-1:0]        shared_budget,
    input  logic [tqbda_pkg::CFG_W-1:0]        comp_budget,
    output tqbda_pkg::decision_t               decision
);

    logic [tqbda_pkg::CNT_W-1:0] sb_eff;
    logic [tqbda_pkg::CNT_W-1:0] cb_eff;
    logic [tqbda_pkg::CNT_W-1:0] cnt_new;
    tqbda_pkg::queue_t           grant;
    logic                        wov;
    logic                        clr;
    logic                        inc;

    assign sb_eff = (shared_budget == '0) ? tqbda_pkg::DEFAULT_SHARED_BUDGET : shared_budget;
    assign cb_eff = (comp_budget == '0) ? tqbda_pkg::DEFAULT_COMP_BUDGET : comp_budget;

    always_comb
    begin
        grant = tqbda_pkg::Q_NONE;
        wov   = 1'b0;
        clr   = 1'b0;
        inc   = 1'b0;
        if (req.shared_overdue)
        begin
            grant = tqbda_pkg::Q_SHARED;
            wov   = 1'b1;
        end
        else if (req.super_overdue)
        begin
            grant = tqbda_pkg::Q_SUPER;
            wov   = 1'b1;
        end
        else if (req.compaction_overdue)
        begin
            grant = tqbda_pkg::Q_COMP;
            wov   = 1'b1;
        end
        else if (in_range && count >= sb_eff && req.shared_ready)
        begin
            grant = tqbda_pkg::Q_SHARED;
            clr   = 1'b1;
        end
        else if (in_range && count >= cb_eff && req.compaction_ready)
        begin
            grant = tqbda_pkg::Q_COMP;
            clr   = 1'b1;
        end
        else if (req.super_ready)
        begin
            grant = tqbda_pkg::Q_SUPER;
            inc   = 1'b1;
        end
        else if (req.compaction_ready)
        begin
            grant = tqbda_pkg::Q_COMP;
            clr   = 1'b1;
        end
        else if (req.shared_ready)
        begin
            grant = tqbda_pkg::Q_SHARED;
            clr   = 1'b1;
        end
    end

    always_comb
    begin
        cnt_new = count;
        if (clr)
        begin
            cnt_new = '0;
        end
        else if (inc && count != tqbda_pkg::COUNT_MAX)
        begin
            cnt_new = count + 16'd1;
        end
    end

    always_comb
    begin
        decision.result.granted_queue = grant;
        decision.result.wait_override = wov;
        decision.result.run_count     = in_range ? cnt_new : '0;
        decision.cnt_write            = in_range;
        decision.cnt_next             = cnt_new;
    end

endmodule

FILE: rtl/three_queue_budget_dispatch_arbiter_top.sv
// Pipeline: the s1 register holds an accepted word, the output register its grant.
// Throughput: one word per cycle unless stalled; the counter RAM read is issued at
//   acceptance, a write-back bypass covers back-to-back requests from the same processor.
// Reset: budgets return to 3 and 2, per-processor valid bits clear so every run counter
//   reads as zero at once; no clearing pass, input is taken right after reset.
`include "three_queue_budget_dispatch_arbiter_top_macros.svh"

module three_queue_budget_dispatch_arbiter_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  tqbda_pkg::req_t                   in_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output tqbda_pkg::grant_t                 out_word,
    input  logic                              cfg_write,
    input  logic [tqbda_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tqbda_pkg::CFG_W-1:0]       cfg_data
);

    logic [tqbda_pkg::CFG_W-1:0]      shared_budget_reg;
    logic [tqbda_pkg::CFG_W-1:0]      comp_budget_reg;

    logic                             s1_valid_reg;
    tqbda_pkg::req_t                  s1_req_reg;
    logic                             out_valid_reg;
    tqbda_pkg::grant_t                out_word_reg;

    logic [tqbda_pkg::NUM_CPUS-1:0]   cnt_valid_reg;
    logic                             byp_valid_reg;
    logic [tqbda_pkg::CNT_ADDR_W-1:0] byp_addr_reg;
    logic [tqbda_pkg::CNT_W-1:0]      byp_data_reg;

    logic                             in_take;
    logic                             s1_adv;
    logic                             s1_range;
    logic [tqbda_pkg::CNT_ADDR_W-1:0] s1_addr;
    logic [tqbda_pkg::CNT_ADDR_W-1:0] in_addr;
    logic [tqbda_pkg::CNT_W-1:0]      ram_rdata;
    logic [tqbda_pkg::CNT_W-1:0]      s1_count;
    logic                             cnt_we;
    tqbda_pkg::decision_t             dec;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    assign in_addr  = in_word.cpu_index[tqbda_pkg::CNT_ADDR_W-1:0];
    assign s1_addr  = s1_req_reg.cpu_index[tqbda_pkg::CNT_ADDR_W-1:0];
    assign s1_range = {{(32-tqbda_pkg::CPU_W){1'b0}}, s1_req_reg.cpu_index}
                      < 32'(tqbda_pkg::NUM_CPUS);

    // latest write wins over the registered RAM word, which may predate it
    always_comb
    begin
        if (!s1_range)
        begin
            s1_count = '0;
        end
        else if (byp_valid_reg && byp_addr_reg == s1_addr)
        begin
            s1_count = byp_data_reg;
        end
        else if (cnt_valid_reg[s1_addr])
        begin
            s1_count = ram_rdata;
        end
        else
        begin
            s1_count = '0;
        end
    end

    assign cnt_we = s1_adv && dec.cnt_write;

    tqbda_ram #(
        .WIDTH (tqbda_pkg::CNT_W),
        .DEPTH (tqbda_pkg::NUM_CPUS)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cnt_we),
        .wr_addr (s1_addr),
        .wr_data (dec.cnt_next),
        .rd_en   (in_take),
        .rd_addr (in_addr),
        .rd_data (ram_rdata)
    );

    tqbda_decide u_decide (
        .req           (s1_req_reg),
        .in_range      (s1_range),
        .count         (s1_count),
        .shared_budget (shared_budget_reg),
        .comp_budget   (comp_budget_reg),
        .decision      (dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shared_budget_reg <= tqbda_pkg::DEFAULT_SHARED_BUDGET;
            comp_budget_reg   <= tqbda_pkg::DEFAULT_COMP_BUDGET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tqbda_pkg::REG_SHARED_BUDGET: shared_budget_reg <= cfg_data;
                tqbda_pkg::REG_COMP_BUDGET:   comp_budget_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_valid_reg <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cnt_we)
            begin
                cnt_valid_reg[s1_addr] <= 1'b1;
                byp_valid_reg          <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_req_reg <= in_word;
        end
        if (s1_adv)
        begin
            out_word_reg <= dec.result;
        end
        if (cnt_we)
        begin
            byp_addr_reg <= s1_addr;
            byp_data_reg <= dec.cnt_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    `TQBDA_CHECK_NOW(a_override_grants,
        out_valid && out_word.wait_override,
        out_word.granted_queue != tqbda_pkg::Q_NONE)
    `TQBDA_CHECK_NOW(a_super_counts,
        out_valid && !out_word.wait_override && out_word.granted_queue == tqbda_pkg::Q_SUPER,
        out_word.run_count != '0)
    `TQBDA_CHECK_NOW(a_other_clears,
        out_valid && !out_word.wait_override
            && (out_word.granted_queue == tqbda_pkg::Q_SHARED
                || out_word.granted_queue == tqbda_pkg::Q_COMP),
        out_word.run_count == '0)
    `TQBDA_CHECK_NEXT(a_s1_holds,
        s1_valid_reg && !s1_adv,
        s1_valid_reg && $stable(s1_req_reg))

endmodule

FILE: bench/three_queue_budget_dispatch_arbiter_top_tb.sv
module three_queue_budget_dispatch_arbiter_top_tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int CALM_RUN    = 40;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLEAR,
        CNT_BUMP
    } cnt_op_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    tqbda_pkg::req_t                 in_word   = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    tqbda_pkg::grant_t               out_word;
    logic                            cfg_write = 1'b0;
    logic [tqbda_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tqbda_pkg::CFG_W-1:0]     cfg_data  = '0;

    // arbiter state as the bench sees it
    logic [tqbda_pkg::CNT_W-1:0] run_cnt [tqbda_pkg::NUM_CPUS];
    logic [tqbda_pkg::CNT_W-1:0] shared_budget = tqbda_pkg::DEFAULT_SHARED_BUDGET;
    logic [tqbda_pkg::CNT_W-1:0] comp_budget   = tqbda_pkg::DEFAULT_COMP_BUDGET;

    tqbda_pkg::req_t   requests_waiting[$];
    tqbda_pkg::grant_t grants_due[$];

    int  mismatches   = 0;
    int  results_seen = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;
    bit  calm         = 1'b0;
    longint cycles    = 0;

    three_queue_budget_dispatch_arbiter_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // grant decision plus run counter update for one request
    function automatic tqbda_pkg::grant_t arbitrate(tqbda_pkg::req_t r);
        tqbda_pkg::grant_t           g;
        logic                        in_range;
        logic [tqbda_pkg::CNT_W-1:0] cnt;
        logic [tqbda_pkg::CNT_W-1:0] sb;
        logic [tqbda_pkg::CNT_W-1:0] cb;
        cnt_op_t                     op;
        in_range = (int'(r.cpu_index) < tqbda_pkg::NUM_CPUS);
        cnt = in_range ? run_cnt[r.cpu_index] : '0;
        sb = (shared_budget == '0) ? tqbda_pkg::DEFAULT_SHARED_BUDGET : shared_budget;
        cb = (comp_budget == '0) ? tqbda_pkg::DEFAULT_COMP_BUDGET : comp_budget;
        g.granted_queue = tqbda_pkg::Q_NONE;
        g.wait_override = 1'b0;
        op = CNT_HOLD;
        if (r.shared_overdue)
        begin
            g.granted_queue = tqbda_pkg::Q_SHARED;
            g.wait_override = 1'b1;
        end
        else if (r.super_overdue)
        begin
            g.granted_queue = tqbda_pkg::Q_SUPER;
            g.wait_override = 1'b1;
        end
        else if (r.compaction_overdue)
        begin
            g.granted_queue = tqbda_pkg::Q_COMP;
            g.wait_override = 1'b1;
        end
        else if (in_range && cnt >= sb && r.shared_ready)
        begin
            g.granted_queue = tqbda_pkg::Q_SHARED;
            op = CNT_CLEAR;
        end
        else if (in_range && cnt >= cb && r.compaction_ready)
        begin
            g.granted_queue = tqbda_pkg::Q_COMP;
            op = CNT_CLEAR;
        end
        else if (r.super_ready)
        begin
            g.granted_queue = tqbda_pkg::Q_SUPER;
            op = CNT_BUMP;
        end
        else if (r.compaction_ready)
        begin
            g.granted_queue = tqbda_pkg::Q_COMP;
            op = CNT_CLEAR;
        end
        else if (r.shared_ready)
        begin
            g.granted_queue = tqbda_pkg::Q_SHARED;
            op = CNT_CLEAR;
        end
        if (in_range)
        begin
            if (op == CNT_CLEAR)
                cnt = '0;
            else if (op == CNT_BUMP && cnt != tqbda_pkg::COUNT_MAX)
                cnt = cnt + 1'b1;
            run_cnt[r.cpu_index] = cnt;
        end
        g.run_count = in_range ? cnt : '0;
        return g;
    endfunction

    function automatic tqbda_pkg::req_t pack_req(int cpu, bit sh, bit su, bit co,
                                                 bit sh_od, bit su_od, bit co_od);
        tqbda_pkg::req_t r;
        r.cpu_index          = cpu[tqbda_pkg::CPU_W-1:0];
        r.shared_ready       = sh;
        r.super_ready        = su;
        r.compaction_ready   = co;
        r.shared_overdue     = sh_od;
        r.super_overdue      = su_od;
        r.compaction_overdue = co_od;
        return r;
    endfunction

    // mostly a few hot processors with super work so counters climb to the budgets
    function automatic tqbda_pkg::req_t random_req();
        int cpu;
        bit od;
        cpu = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3)
                                            : $urandom_range(0, tqbda_pkg::NUM_CPUS - 1);
        od = ($urandom_range(0, 99) < 12);
        return pack_req(cpu, $urandom_range(0, 99) < 45, $urandom_range(0, 99) < 70,
                        $urandom_range(0, 99) < 40,
                        od && $urandom_range(0, 1), od && $urandom_range(0, 1),
                        od && $urandom_range(0, 1));
    endfunction

    task automatic set_budget(input logic [tqbda_pkg::CFG_IDX_W-1:0] idx,
                              input logic [tqbda_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == tqbda_pkg::REG_SHARED_BUDGET)
            shared_budget = val;
        else
            comp_budget = val;
    endtask

    task automatic drain();
        while (requests_waiting.size() != 0 || grants_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_random(int n);
        repeat (n) requests_waiting.push_back(random_req());
    endtask

    // driver: a stalled word holds, otherwise maybe idle, otherwise offer the next one
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && in_stall)
        begin
            // hold the word
        end
        else
        begin
            if (in_valid)
            begin
                grants_due.push_back(arbitrate(in_word));
                void'(requests_waiting.pop_front());
            end
            if (requests_waiting.size() != 0 && (calm || $urandom_range(0, 99) >= 38))
            begin
                in_valid <= 1'b1;
                in_word  <= requests_waiting[0];
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        tqbda_pkg::grant_t exp_g;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (grants_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected grant word: queue %0d override %0d count %0d",
                                 out_word.granted_queue, out_word.wait_override,
                                 out_word.run_count);
                    mismatches++;
                end
                else
                begin
                    exp_g = grants_due.pop_front();
                    if (out_word.granted_queue !== exp_g.granted_queue
                        || out_word.wait_override !== exp_g.wait_override
                        || out_word.run_count !== exp_g.run_count)
                    begin
                        if (mismatches < 10)
                            $display("grant mismatch: exp q%0d ov%0d cnt%0d got q%0d ov%0d cnt%0d",
                                     exp_g.granted_queue, exp_g.wait_override,
                                     exp_g.run_count, out_word.granted_queue,
                                     out_word.wait_override, out_word.run_count);
                        mismatches++;
                    end
                end
            end
            // one long back-pressure stretch so the input side fills and stalls
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && results_seen >= 150)
            begin
                hold_done = 1'b1;
                hold_left = 119;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(0, 99) < 38);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < tqbda_pkg::NUM_CPUS; i++)
            run_cnt[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset budgets: forced compaction, forced shared, every plain rule
        requests_waiting.push_back(pack_req(0, 0, 1, 0, 0, 0, 0));
        requests_waiting.push_back(pack_req(0, 0, 1, 0, 0, 0, 0));
        requests_waiting.push_back(pack_req(0, 0, 1, 1, 0, 0, 0));
        requests_waiting.push_back(pack_req(0, 0, 1, 0, 0, 0, 0));
        requests_waiting.push_back(pack_req(0, 0, 1, 0, 0, 0, 0));
        requests_waiting.push_back(pack_req(0, 0, 1, 0, 0, 0, 0));
        requests_waiting.push_back(pack_req(0, 1, 1, 1, 0, 0, 0));
        requests_waiting.push_back(pack_req(0, 0, 0, 1, 0, 0, 0));
        requests_waiting.push_back(pack_req(0, 1, 0, 0, 0, 0, 0));
        requests_waiting.push_back(pack_req(0, 0, 0, 0, 0, 0, 0));
        // overdue with the queue empty, then each overdue level
        requests_waiting.push_back(pack_req(63, 0, 0, 0, 1, 0, 0));
        requests_waiting.push_back(pack_req(63, 1, 0, 0, 0, 1, 0));
        requests_waiting.push_back(pack_req(63, 0, 1, 0, 0, 0, 1));
        requests_waiting.push_back(pack_req(63, 1, 1, 1, 1, 1, 1));
        requests_waiting.push_back(pack_req(63, 0, 1, 0, 0, 0, 0));
        requests_waiting.push_back(pack_req(63, 0, 1, 0, 0, 1, 0));
        requests_waiting.push_back(pack_req(42, 1, 1, 1, 0, 0, 0));
        queue_random(180);
        drain();

        // zero selects the default budgets
        set_budget(tqbda_pkg::REG_SHARED_BUDGET, '0);
        set_budget(tqbda_pkg::REG_COMP_BUDGET, '0);
        queue_random(90);
        drain();

        set_budget(tqbda_pkg::REG_SHARED_BUDGET, 16'd1);
        set_budget(tqbda_pkg::REG_COMP_BUDGET, 16'hFFFF);
        queue_random(90);
        drain();

        // long super run on one processor, no idling on either side
        calm = 1'b1;
        set_budget(tqbda_pkg::REG_SHARED_BUDGET, 16'hFFFF);
        repeat (CALM_RUN) requests_waiting.push_back(pack_req(5, 0, 1, 0, 0, 0, 0));
        requests_waiting.push_back(pack_req(5, 0, 1, 1, 0, 0, 0));
        requests_waiting.push_back(pack_req(5, 1, 1, 1, 0, 0, 0));
        requests_waiting.push_back(pack_req(5, 0, 1, 0, 0, 0, 0));
        drain();
        calm = 1'b0;

        set_budget(tqbda_pkg::REG_SHARED_BUDGET, 16'd4);
        set_budget(tqbda_pkg::REG_COMP_BUDGET, 16'd7);
        queue_random(230);
        drain();

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/tqbda_pkg.sv
rtl/tqbda_ram.sv
rtl/tqbda_decide.sv
rtl/three_queue_budget_dispatch_arbiter_top.sv
bench/three_queue_budget_dispatch_arbiter_top_tb.sv
